// ===== design/kli_pkg.sv =====
// shared types and constants of the keyframe linear interpolator
`default_nettype none
package kli_pkg;

  localparam int POS_W   = 16;
  localparam int VAL_W   = 16;
  localparam int WORD_W  = POS_W + VAL_W;
  localparam int PROD_W  = 2 * (VAL_W + 1);
  localparam int MAG_W   = 32;
  localparam int DCNT_W  = 5;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_EVAL,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic res_clear;
    logic set_drop;
    logic clear_cnt;
    logic ins_start;
    logic rd_prev;
    logic ins_shift;
    logic ins_place;
    logic q_start;
    logic q_acc;
    logic eval;
    logic mul;
    logic div_init;
    logic div_step;
    logic fix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       full;
    logic       empty;
    logic       slot_zero;
    logic       shift_more;
    logic       scan_last;
    logic       interp;
    logic       div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/keyframe_linear_interpolator.sv =====
// top level of the keyframe linear interpolator
//
//   channel  signals                                   direction
//   in       in_valid in_stall action position key_value   into block
//   out      out_valid out_stall result_value status entry_count  out of block
//
// clear, unused codes, dropped inserts and empty-table queries go from dispatch straight to done;
// insert moves each stored entry with a greater position up one slot, then writes the new entry
// query scans every stored entry, then between keyframes runs the multiply and the
// serial divide; the single table port sets the scan rate
// rst is synchronous and clears the state machine, the entry count and the output valid
// a new word is taken while a finished result waits under out_stall
`default_nettype none
module keyframe_linear_interpolator #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [1:0]                              action,
  input  wire logic [kli_pkg::POS_W-1:0]               position,
  input  wire logic signed [kli_pkg::VAL_W-1:0]        key_value,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [kli_pkg::VAL_W-1:0]             result_value,
  output logic                                         status,
  output logic [$clog2(MAX_KEYFRAMES+1)-1:0]           entry_count
);
  import kli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kli_datapath #(
    .MAX_KEYFRAMES(MAX_KEYFRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_action   (action),
    .in_position (position),
    .in_key_value(key_value),
    .cmd         (cmd),
    .sts         (sts),
    .result_value(result_value),
    .status      (status),
    .entry_count (entry_count)
  );
endmodule
`default_nettype wire

// ===== design/kli_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/kli_ctrl.sv =====
// sequencing state machine of the keyframe interpolator
`default_nettype none
module kli_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire kli_pkg::sts_t sts,
  output kli_pkg::cmd_t      cmd
);
  import kli_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.res_clear = 1'b1;
        state_next    = ST_DONE;
        case (sts.act)
          ACT_INSERT: begin
            if (sts.full) begin
              cmd.set_drop = 1'b1;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = ST_INS_RD;
            end
          end
          ACT_QUERY: begin
            if (!sts.empty) begin
              cmd.q_start = 1'b1;
              state_next  = ST_QRY_RD;
            end
          end
          ACT_CLEAR: cmd.clear_cnt = 1'b1;
          default: ;
        endcase
      end
      ST_INS_RD: begin
        if (sts.slot_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = ST_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.shift_more) begin
          cmd.ins_shift = 1'b1;
          state_next    = ST_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_QRY_RD: state_next = ST_QRY_ACC;
      ST_QRY_ACC: begin
        cmd.q_acc  = 1'b1;
        state_next = sts.scan_last ? ST_EVAL : ST_QRY_RD;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (sts.interp) begin
          cmd.mul    = 1'b1;
          state_next = ST_DIV_INIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/kli_datapath.sv =====
// keyframe table, scan registers, multiplier and serial divider
`default_nettype none
module kli_datapath #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [1:0]                             in_action,
  input  wire logic [kli_pkg::POS_W-1:0]              in_position,
  input  wire logic signed [kli_pkg::VAL_W-1:0]       in_key_value,
  input  wire kli_pkg::cmd_t                          cmd,
  output kli_pkg::sts_t                               sts,
  output logic signed [kli_pkg::VAL_W-1:0]            result_value,
  output logic                                        status,
  output logic [$clog2(MAX_KEYFRAMES+1)-1:0]          entry_count
);
  import kli_pkg::*;

  localparam int IW = $clog2(MAX_KEYFRAMES);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);

  logic [1:0]               act;
  logic [POS_W-1:0]         qpos;
  logic signed [VAL_W-1:0]  qval;
  logic [CW-1:0]            count;
  logic [IW-1:0]            idx;

  logic                     we;
  logic [WORD_W-1:0]        wdata;
  logic [IW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;
  logic [POS_W-1:0]         ex;
  logic signed [VAL_W-1:0]  ev;

  logic [POS_W-1:0]         x0, xl, lo_x, hi_x;
  logic signed [VAL_W-1:0]  v0, vl, lo_v, hi_v;
  logic                     hi_ok;

  logic                     interp;
  logic signed [VAL_W:0]    dv;
  logic [POS_W-1:0]         off, dx;
  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic [MAG_W-1:0]         quo;
  logic [POS_W-1:0]         rem;
  logic [DCNT_W-1:0]        dcnt;
  logic [POS_W:0]           sh;
  logic [POS_W:0]           trial;
  logic signed [VAL_W+1:0]  qsig;
  logic signed [VAL_W+1:0]  sum;

  logic signed [VAL_W-1:0]  res_val;
  logic                     res_drop;

  assign ex = rdata[WORD_W-1:VAL_W];
  assign ev = rdata[VAL_W-1:0];

  assign raddr = cmd.rd_prev ? idx - IW'(1) : idx;
  assign we    = cmd.ins_shift || cmd.ins_place;
  assign wdata = cmd.ins_shift ? rdata : {qpos, qval};

  kli_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_KEYFRAMES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(idx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // restoring divide: one quotient bit per cycle
  assign sh    = {rem, quo[MAG_W-1]};
  assign trial = sh - {1'b0, dx};
  assign qsig  = neg ? -$signed({1'b0, quo[VAL_W:0]}) : $signed({1'b0, quo[VAL_W:0]});
  assign sum   = {{2{lo_v[VAL_W-1]}}, lo_v} + qsig;

  always_comb begin
    sts            = '0;
    sts.act        = act;
    sts.full       = (count == CW'(MAX_KEYFRAMES));
    sts.empty      = (count == '0);
    sts.slot_zero  = (idx == '0);
    sts.shift_more = (ex > qpos);
    sts.scan_last  = (CW'(idx) == count - CW'(1));
    sts.interp     = interp;
    sts.div_last   = (dcnt == '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_cnt) begin
      count <= '0;
    end else if (cmd.ins_place) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act  <= in_action;
      qpos <= in_position;
      qval <= in_key_value;
    end
    if (cmd.res_clear) begin
      res_val  <= '0;
      res_drop <= cmd.set_drop;
    end
    if (cmd.ins_start) begin
      idx <= count[IW-1:0];
    end else if (cmd.ins_shift) begin
      idx <= idx - IW'(1);
    end else if (cmd.q_start) begin
      idx <= '0;
    end else if (cmd.q_acc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.q_start) begin
      hi_ok <= 1'b0;
    end
    if (cmd.q_acc) begin
      if (idx == '0) begin
        x0 <= ex;
        v0 <= ev;
      end
      xl <= ex;
      vl <= ev;
      // lo tracks the last entry at or below the query, hi the last of the next group
      if (ex <= qpos) begin
        lo_x <= ex;
        lo_v <= ev;
      end else if (!hi_ok || ex == hi_x) begin
        hi_x  <= ex;
        hi_v  <= ev;
        hi_ok <= 1'b1;
      end
    end
    if (cmd.eval) begin
      if (qpos <= x0) begin
        res_val <= v0;
        interp  <= 1'b0;
      end else if (qpos >= xl) begin
        res_val <= vl;
        interp  <= 1'b0;
      end else if (lo_x == qpos) begin
        res_val <= lo_v;
        interp  <= 1'b0;
      end else begin
        interp <= 1'b1;
      end
      dv  <= {hi_v[VAL_W-1], hi_v} - {lo_v[VAL_W-1], lo_v};
      off <= qpos - lo_x;
      dx  <= hi_x - lo_x;
    end
    if (cmd.mul) begin
      prod <= dv * $signed({1'b0, off});
    end
    if (cmd.div_init) begin
      neg  <= prod[PROD_W-1];
      quo  <= prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + DCNT_W'(1);
      if (!trial[POS_W]) begin
        rem <= trial[POS_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b1};
      end else begin
        rem <= sh[POS_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.fix) begin
      res_val <= sum[VAL_W-1:0];
    end
    if (cmd.load_out) begin
      result_value <= res_val;
      status       <= res_drop;
      entry_count  <= count;
    end
  end
endmodule
`default_nettype wire

// ===== design/kli_checker.sv =====
// port-level checks of the keyframe linear interpolator and their bind
`default_nettype none
module kli_checker #(
  parameter int MAX_KEYFRAMES = 64
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic [15:0]                          result_value,
  input wire logic                                 status,
  input wire logic [$clog2(MAX_KEYFRAMES+1)-1:0]   entry_count
);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled result changed");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> entry_count == CW'(MAX_KEYFRAMES) && result_value == 16'd0)
    else $error("dropped insert with table not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CW'(MAX_KEYFRAMES))
    else $error("entry count above table size");
endmodule

bind keyframe_linear_interpolator kli_checker #(
  .MAX_KEYFRAMES(MAX_KEYFRAMES)
) u_kli_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_value(result_value),
  .status      (status),
  .entry_count (entry_count)
);
`default_nettype wire

// ===== test/keyframe_linear_interpolator_tb.sv =====
// testbench of the keyframe linear interpolator: predicts each result and checks it
`default_nettype none
module keyframe_linear_interpolator_tb;
  import kli_pkg::*;

  localparam int NKEY = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_CLEAR;
  logic [POS_W-1:0] position = '0;
  logic signed [VAL_W-1:0] key_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] result_value;
  logic status;
  logic [6:0] entry_count;

  keyframe_linear_interpolator #(.MAX_KEYFRAMES(NKEY)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .key_value(key_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .status(status), .entry_count(entry_count)
  );

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    dropped;
    logic [6:0]              count;
  } answer_t;

  // predicted table
  logic [POS_W-1:0]        tbl_pos[NKEY];
  logic signed [VAL_W-1:0] tbl_val[NKEY];
  int                      tbl_n;

  answer_t pending_answers[$];
  int  mismatches;
  int  idle_cycles;
  bit  quiet;   // no idling on either side

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] interp_at(logic [POS_W-1:0] p);
    int lo, hi;
    longint dv, dx, off;
    if (tbl_n == 0) return '0;
    if (p <= tbl_pos[0]) return tbl_val[0];
    if (p >= tbl_pos[tbl_n-1]) return tbl_val[tbl_n-1];
    lo = 0;
    while (lo + 1 < tbl_n && tbl_pos[lo+1] <= p) lo++;
    if (tbl_pos[lo] == p) return tbl_val[lo];
    hi = lo + 1;
    while (hi + 1 < tbl_n && tbl_pos[hi+1] == tbl_pos[lo+1]) hi++;
    dv = longint'(tbl_val[hi]) - longint'(tbl_val[lo]);
    dx = longint'(tbl_pos[hi]) - longint'(tbl_pos[lo]);
    off = longint'(p) - longint'(tbl_pos[lo]);
    return VAL_W'(longint'(tbl_val[lo]) + (dv * off) / dx);
  endfunction

  function automatic answer_t apply_word(logic [1:0] a, logic [POS_W-1:0] p,
                                         logic signed [VAL_W-1:0] v);
    answer_t r;
    int s;
    r = '0;
    case (a)
      ACT_INSERT: begin
        if (tbl_n >= NKEY) r.dropped = 1'b1;
        else begin
          s = tbl_n;
          while (s > 0 && tbl_pos[s-1] > p) begin
            tbl_pos[s] = tbl_pos[s-1];
            tbl_val[s] = tbl_val[s-1];
            s--;
          end
          tbl_pos[s] = p;
          tbl_val[s] = v;
          tbl_n++;
        end
      end
      ACT_QUERY: r.value = interp_at(p);
      ACT_CLEAR: tbl_n = 0;
      default: ;
    endcase
    r.count = 7'(tbl_n);
    return r;
  endfunction

  task automatic send_word(logic [1:0] a, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
    answer_t ans;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 12) @(negedge clk);
    action <= a;
    position <= p;
    key_value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans = apply_word(a, p, v);
    pending_answers = {pending_answers, ans};
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // stall on the result side
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst) idle_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value %0d status %0d count %0d",
                                       result_value, status, entry_count);
      end else begin
        e = pending_answers.pop_front();
        if (e.value !== result_value || e.dropped !== status || e.count !== entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d status %0d count %0d, got %0d %0d %0d",
                     e.value, e.dropped, e.count, result_value, status, entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("keyframe_linear_interpolator_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_val();
    return VAL_W'($urandom);
  endfunction

  task automatic test_directed;
    send_word(ACT_QUERY, 16'd100, '0);           // empty table
    send_word(ACT_INSERT, 16'd0, 16'sh8000);
    send_word(ACT_QUERY, 16'd0, '0);
    send_word(ACT_INSERT, 16'hFFFF, 16'sh7FFF);
    send_word(ACT_QUERY, 16'h8000, '0);          // widest span
    send_word(ACT_QUERY, 16'hFFFF, '0);
    send_word(ACT_INSERT, 16'd1000, 16'sd256);
    send_word(ACT_INSERT, 16'd1000, -16'sd512);  // duplicate position goes after
    send_word(ACT_QUERY, 16'd1000, '0);
    send_word(ACT_QUERY, 16'd999, '0);
    send_word(ACT_QUERY, 16'd1001, '0);
    send_word(ACT_QUERY, 16'd500, '0);
    send_word(ACT_UNUSED, 16'hFFFF, 16'shFFFF);
    send_word(ACT_CLEAR, 16'd0, '0);
    send_word(ACT_INSERT, 16'd50, 16'sd10);
    send_word(ACT_QUERY, 16'd10, '0);            // single entry
    send_word(ACT_QUERY, 16'd60, '0);
    send_word(ACT_CLEAR, 16'd0, '0);
  endtask

  task automatic test_full_table;
    for (int i = 0; i < NKEY + 2; i++)
      send_word(ACT_INSERT, 16'($urandom_range(65535, 0)), rand_val());
    for (int i = 0; i < 6; i++) send_word(ACT_QUERY, 16'($urandom), '0);
    send_word(ACT_CLEAR, '0, '0);
  endtask

  // batches of mixed inserts and queries from mostly small position pools, then queries, with noise
  task automatic test_random(int items);
    int done_n, span, fill;
    done_n = 0;
    while (done_n < items) begin
      span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(200, 4);
      fill = $urandom_range(NKEY + 4, 1);
      for (int i = 0; i < fill && done_n < items; i++) begin
        if ($urandom_range(9) < 6) send_word(ACT_INSERT, 16'($urandom_range(span)), rand_val());
        else send_word(ACT_QUERY, 16'($urandom_range(span + 3)), rand_val());
        done_n++;
      end
      for (int i = 0; i < 8; i++) begin
        send_word($urandom_range(19) == 0 ? ACT_UNUSED : ACT_QUERY,
                  16'($urandom_range(span + 3)), rand_val());
        done_n++;
      end
      if ($urandom_range(9) == 0) begin
        drain();                                   // sender waits for all results
      end
      send_word(ACT_CLEAR, 16'($urandom), rand_val());
      done_n++;
    end
  endtask

  initial begin
    mismatches = 0;
    tbl_n = 0;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    drain();
    test_random(700);
    quiet = 1'b1;
    test_random(300);
    quiet = 1'b0;
    test_random(350);
    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("keyframe_linear_interpolator_tb: PASS");
    else
      $display("keyframe_linear_interpolator_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/kli_pkg.sv
design/kli_ram.sv
design/kli_ctrl.sv
design/kli_datapath.sv
design/keyframe_linear_interpolator.sv
design/kli_checker.sv
test/keyframe_linear_interpolator_tb.sv
